### hw/rtl/rcfd_pkg.sv
// rcfd_pkg: shared types, codes and constant helpers for the RC frame decoder.
// Depends on nothing; imported by every rcfd module.
package rcfd_pkg;

  // Input item modes
  localparam logic [1:0] MODE_DATA = 2'd0;
  localparam logic [1:0] MODE_END  = 2'd1;
  localparam logic [1:0] MODE_ERR  = 2'd2;

  // Frame status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_COUNT = 2'd1;
  localparam logic [1:0] STAT_CHECK = 2'd2;

  // Servo command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_HEADER = 3'd0;
  localparam logic [2:0] CFG_WEIGHT = 3'd1;
  localparam logic [2:0] CFG_LIDAR  = 3'd2;
  localparam logic [2:0] CFG_BARO   = 3'd3;
  localparam logic [2:0] CFG_RSSI   = 3'd4;

  // 4508 * round(ln2 * 2^32), split into two 22-bit halves
  localparam logic [43:0] LOG_SCALE = 44'd13420516479776;
  localparam logic [21:0] K_LO = LOG_SCALE[21:0];
  localparam logic [21:0] K_HI = LOG_SCALE[43:22];

  // Frame record handed from front to back
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] throttle;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [7:0]  mode_byte;
    logic [7:0]  rssi;
  } frame_rec_t;

  // Dallas CRC-8, reflected polynomial 0x8C, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

  // log2 fraction in Q16 by repeated squaring in Q30 (elaboration only)
  function automatic logic [16:0] log_q16(input logic [63:0] x0);
    logic [63:0] x;
    logic [16:0] res;
    x = x0;
    res = '0;
    for (int k = 15; k >= 0; k--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/rcfd_front.sv
// rcfd_front: collects frame bytes, runs the CRC and classifies each frame end.
// Depends on rcfd_pkg; feeds rcfd_queue.
module rcfd_front import rcfd_pkg::*; #(
  parameter int FRAME_BYTES = 13
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [7:0] rx_byte,
  input  logic [7:0] header_value,
  input  logic       rssi_present,
  input  logic       full,
  output logic       push,
  output frame_rec_t push_rec
);

  localparam int STORE_DEPTH = FRAME_BYTES + 1;
  localparam int SW = $clog2(STORE_DEPTH);

  logic [7:0] store [STORE_DEPTH];
  logic [4:0] byte_count;
  logic [7:0] crc;
  logic       accept;
  logic [4:0] expected;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (mode == MODE_END);

  // Byte counter and CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      crc        <= '0;
    end else if (accept) begin
      case (mode)
        MODE_DATA: begin
          if (byte_count < 5'(FRAME_BYTES - 2)) crc <= crc8_update(crc, rx_byte);
          if (byte_count != 5'd31) byte_count <= byte_count + 5'd1;
        end
        MODE_END, MODE_ERR: begin
          byte_count <= '0;
          crc        <= '0;
        end
        default: ;
      endcase
    end
  end

  // Frame byte store
  always_ff @(posedge clk) begin
    if (accept && mode == MODE_DATA && byte_count < 5'(STORE_DEPTH))
      store[byte_count[SW-1:0]] <= rx_byte;
  end

  // Classification at frame end
  assign expected = 5'(FRAME_BYTES) + {4'b0, rssi_present};

  always_comb begin
    if (byte_count != expected) push_rec.status = STAT_COUNT;
    else if (store[0] != header_value || store[FRAME_BYTES-2] != crc)
      push_rec.status = STAT_CHECK;
    else push_rec.status = STAT_OK;
    push_rec.throttle  = {store[1], store[2]};
    push_rec.roll      = {store[3], store[4]};
    push_rec.pitch     = {store[5], store[6]};
    push_rec.yaw       = {store[7], store[8]};
    push_rec.mode_byte = store[10];
    push_rec.rssi      = rssi_present ? store[FRAME_BYTES] : 8'd0;
  end

endmodule

### hw/rtl/rcfd_queue.sv
// rcfd_queue: two-entry queue of frame records between front and back.
// Depends on rcfd_pkg.
module rcfd_queue import rcfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output logic       rec_valid,
  output frame_rec_t rec
);

  frame_rec_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign rec_valid = (count != 2'd0);
  assign rec       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

endmodule

### hw/rtl/rcfd_back.sv
// rcfd_back: sequencer that maps, filters and flags one frame record at a time.
// Depends on rcfd_pkg; reads records from rcfd_queue.
module rcfd_back import rcfd_pkg::*; #(
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rec_valid,
  input  frame_rec_t        rec,
  output logic              pop,
  input  logic [8:0]        filter_weight,
  input  logic              lidar_hold_enable,
  input  logic              baro_hold_enable,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        frame_status,
  output logic [15:0]       raw_throttle_filtered,
  output logic [15:0]       throttle_level,
  output logic signed [13:0] pitch_angle,
  output logic signed [13:0] roll_angle,
  output logic signed [16:0] yaw_rate,
  output logic [7:0]        switch_bits,
  output logic [2:0]        flight_flags,
  output logic signed [7:0] signal_strength,
  output logic [1:0]        aux_command,
  output logic [1:0]        arm_command
);

  localparam int IW   = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int NUMW = 16 + IW;
  localparam logic [31:0] RECIP_6   = 32'((64'd1 << 32) / 6);
  localparam logic [31:0] RECIP_374 = 32'((64'd1 << 32) / 374);
  localparam logic [31:0] RECIP_206 = 32'((64'd1 << 32) / 206);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOG0 = 4'd1;
  localparam logic [3:0] ST_LOG1 = 4'd2;
  localparam logic [3:0] ST_LOG2 = 4'd3;
  localparam logic [3:0] ST_LOG3 = 4'd4;
  localparam logic [3:0] ST_LOG4 = 4'd5;
  localparam logic [3:0] ST_LOG5 = 4'd6;
  localparam logic [3:0] ST_MAP0 = 4'd7;
  localparam logic [3:0] ST_MAP1 = 4'd8;
  localparam logic [3:0] ST_MAP2 = 4'd9;
  localparam logic [3:0] ST_FA   = 4'd10;
  localparam logic [3:0] ST_FB   = 4'd11;
  localparam logic [3:0] ST_FLAG = 4'd12;
  localparam logic [3:0] ST_FAIL = 4'd13;

  // Log table, built at elaboration
  logic [16:0] rom [LOG_TABLE_DEPTH + 1];
  for (genvar g = 0; g <= LOG_TABLE_DEPTH; g++) begin : g_rom
    if (g == LOG_TABLE_DEPTH) begin : g_last
      assign rom[g] = 17'd65536;
    end else begin : g_entry
      localparam logic [63:0] XS = (64'd1 << 30) + ((64'(g) << 30) / LOG_TABLE_DEPTH);
      assign rom[g] = log_q16(XS);
    end
  end

  logic [3:0]  state;
  frame_rec_t  cur;
  logic [1:0]  ch;
  logic [2:0]  fch;
  logic signed [17:0] x    [5];
  logic signed [17:0] ymem [5];
  logic [3:0]  e;
  logic [IW-1:0] li;
  logic [15:0] rem;
  logic [16:0] base;
  logic [31:0] iprod;
  logic [20:0] lq;
  logic [42:0] pl;
  logic [42:0] ph;
  logic [23:0] map_a;
  logic [8:0]  map_d2;
  logic [31:0] map_m;
  logic        map_neg;
  logic [55:0] prodm;
  logic signed [27:0] fmul;
  logic [2:0]  flags;
  logic [1:0]  permits;
  logic [7:0]  prev_sw;
  logic        prev_armed;

  logic        out_free;
  assign out_free = !out_valid || out_ready;
  assign pop = (state == ST_IDLE) && rec_valid;

  // Log front end: exponent, table index and remainder
  logic [15:0]     t_cl;
  logic [3:0]      e_c;
  logic [15:0]     frac_c;
  logic [NUMW-1:0] num_c;
  logic [NUMW-1:0] ifull_c;
  logic [IW-1:0]   li_c;
  logic [NUMW-1:0] rem_c;
  always_comb begin
    t_cl = (cur.throttle == 16'd0) ? 16'd1 : cur.throttle;
    e_c = '0;
    for (int b = 1; b < 16; b++) begin
      if (t_cl[b]) e_c = 4'(b);
    end
    frac_c  = t_cl - (16'd1 << e_c);
    num_c   = NUMW'(frac_c) * NUMW'(LOG_TABLE_DEPTH);
    ifull_c = num_c >> e_c;
    li_c = (ifull_c >= NUMW'(LOG_TABLE_DEPTH)) ? IW'(LOG_TABLE_DEPTH - 1) : IW'(ifull_c);
    rem_c = num_c - (NUMW'(li_c) << e_c);
  end

  // Level from scaled log
  logic [65:0] lsum_c;
  logic [17:0] lev_c;
  always_comb begin
    lsum_c = {1'b0, ph, 22'b0} + 66'(pl) + (66'd1 << 47);
    lev_c  = 18'd7040 + lsum_c[65:48];
  end

  // Stick map classification
  logic [15:0]        p_c;
  logic               need_div_c;
  logic signed [17:0] const_c;
  logic signed [25:0] nn_c;
  logic [8:0]         d2_c;
  logic [31:0]        m_c;
  always_comb begin
    case (ch)
      2'd0:    p_c = cur.pitch;
      2'd1:    p_c = cur.roll;
      default: p_c = cur.yaw;
    endcase
    need_div_c = 1'b0;
    const_c = '0;
    nn_c = '0;
    d2_c = 9'd6;
    m_c = RECIP_6;
    if (ch != 2'd2) begin
      if (p_c > 16'd360 && p_c < 16'd1800) begin
        need_div_c = 1'b1;
        nn_c = 26'sd2 * (26'sd16 * $signed({10'b0, p_c}) - 26'sd28800) + 26'sd3;
      end else if (p_c > 16'd2245 && p_c < 16'd3741) begin
        need_div_c = 1'b1;
        nn_c = 26'sd2 * ($signed({10'b0, p_c}) - 26'sd2245) * 26'sd960 + 26'sd187;
        d2_c = 9'd374;
        m_c = RECIP_374;
      end else if (p_c >= 16'd3741) const_c = 18'sd7680;
      else if (p_c <= 16'd360) const_c = -18'sd7680;
    end else begin
      d2_c = 9'd206;
      m_c = RECIP_206;
      if (p_c > 16'd200 && p_c < 16'd1848) begin
        need_div_c = 1'b1;
        nn_c = 26'sd2 * (26'sd1848 - $signed({10'b0, p_c})) * 26'sd2400 + 26'sd103;
      end else if (p_c > 16'd2248 && p_c < 16'd3896) begin
        need_div_c = 1'b1;
        nn_c = 26'sd2 * (26'sd2248 - $signed({10'b0, p_c})) * 26'sd2400 + 26'sd103;
      end else if (p_c >= 16'd3896) const_c = -18'sd38400;
      else if (p_c <= 16'd200) const_c = 18'sd38400;
    end
  end

  // Quotient correction after reciprocal multiply
  logic [23:0]        q0_c;
  logic [33:0]        r_c;
  logic [23:0]        q_c;
  logic signed [17:0] qs_c;
  always_comb begin
    q0_c = prodm[55:32];
    r_c  = 34'(map_a) - 34'(q0_c) * 34'(map_d2);
    q_c  = q0_c + ((r_c >= 34'(map_d2)) ? 24'd1 : 24'd0);
    qs_c = map_neg ? -$signed(18'(q_c)) : $signed(18'(q_c));
  end

  // Map value with roll reversed
  logic signed [17:0] mval_c;
  always_comb begin
    mval_c = (state == ST_MAP2) ? qs_c : const_c;
    if (ch == 2'd1) mval_c = -mval_c;
  end

  // Filter weight clamp
  logic [8:0] wc;
  always_comb begin
    if (filter_weight == 9'd0) wc = 9'd1;
    else if (filter_weight > 9'd256) wc = 9'd256;
    else wc = filter_weight;
  end

  logic signed [27:0] facc_c;
  assign facc_c = fmul + $signed({1'b0, 9'd256 - wc}) * ymem[fch] + 28'sd128;

  // Flag logic
  logic [7:0] sw_c;
  logic [2:0] f_c;
  logic [1:0] hp_c;
  logic [1:0] aux_c;
  logic [1:0] armc_c;
  always_comb begin
    sw_c = ~cur.mode_byte;
    f_c  = flags;
    hp_c = permits;
    if (ymem[1] < 18'sd33600 && sw_c[0]) f_c[0] = 1'b1;
    if (!sw_c[0]) begin
      f_c  = '0;
      hp_c = '0;
    end
    if (lidar_hold_enable) begin
      if (sw_c[1] && hp_c[0] && f_c[0]) f_c[1] = 1'b1;
      if (!sw_c[1]) begin
        f_c[1]  = 1'b0;
        hp_c[0] = 1'b1;
      end
    end
    if (baro_hold_enable) begin
      if (sw_c[2] && hp_c[1] && f_c[0]) f_c[2] = 1'b1;
      if (!sw_c[2]) begin
        f_c[2]  = 1'b0;
        hp_c[1] = 1'b1;
      end
    end
    aux_c  = (sw_c[3] != prev_sw[3]) ? (sw_c[3] ? CMD_ON : CMD_OFF) : CMD_NONE;
    armc_c = (f_c[0] != prev_armed) ? (f_c[0] ? CMD_ON : CMD_OFF) : CMD_NONE;
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      flags      <= '0;
      permits    <= '0;
      prev_sw    <= '0;
      prev_armed <= 1'b0;
      for (int k = 0; k < 5; k++) ymem[k] <= '0;
    end else begin
      case (state)
        ST_IDLE: if (rec_valid) state <= (rec.status == STAT_OK) ? ST_LOG0 : ST_FAIL;
        ST_LOG0: state <= ST_LOG1;
        ST_LOG1: state <= ST_LOG2;
        ST_LOG2: state <= ST_LOG3;
        ST_LOG3: state <= ST_LOG4;
        ST_LOG4: state <= ST_LOG5;
        ST_LOG5: state <= ST_MAP0;
        ST_MAP0: begin
          if (need_div_c) state <= ST_MAP1;
          else if (ch == 2'd2) state <= ST_FA;
        end
        ST_MAP1: state <= ST_MAP2;
        ST_MAP2: state <= (ch == 2'd2) ? ST_FA : ST_MAP0;
        ST_FA:   state <= ST_FB;
        ST_FB: begin
          ymem[fch] <= 18'(facc_c >>> 8);
          state <= (fch == 3'd4) ? ST_FLAG : ST_FA;
        end
        ST_FLAG: if (out_free) begin
          flags      <= f_c;
          permits    <= hp_c;
          prev_sw    <= sw_c;
          prev_armed <= f_c[0];
          state      <= ST_IDLE;
        end
        ST_FAIL: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result valid: set when a record finishes, cleared on acceptance
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if ((state == ST_FLAG || state == ST_FAIL) && out_free) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur  <= rec;
        x[0] <= $signed({2'b0, rec.throttle});
        ch   <= '0;
        fch  <= '0;
      end
      ST_LOG0: begin
        e   <= e_c;
        li  <= li_c;
        rem <= 16'(rem_c);
      end
      ST_LOG1: begin
        base  <= rom[li];
        iprod <= 32'(rom[IW'(li + IW'(1))] - rom[li]) * 32'(rem);
      end
      ST_LOG2: lq <= 21'({e, 16'b0}) + 21'(base) + 21'(iprod >> e);
      ST_LOG3: pl <= 43'(lq) * 43'(K_LO);
      ST_LOG4: ph <= 43'(lq) * 43'(K_HI);
      ST_LOG5: x[1] <= (lev_c > 18'd65535) ? 18'sd65535 : $signed(lev_c);
      ST_MAP0: begin
        map_neg <= nn_c < 0;
        map_a   <= (nn_c < 0) ? 24'(-nn_c + 26'(d2_c) - 26'sd1) : 24'(nn_c);
        map_d2  <= d2_c;
        map_m   <= m_c;
        if (!need_div_c) begin
          x[3'(ch) + 3'd2] <= mval_c;
          if (ch != 2'd2) ch <= ch + 2'd1;
        end
      end
      ST_MAP1: prodm <= 56'(map_a) * 56'(map_m);
      ST_MAP2: begin
        x[3'(ch) + 3'd2] <= mval_c;
        if (ch != 2'd2) ch <= ch + 2'd1;
      end
      ST_FA: fmul <= $signed({1'b0, wc}) * x[fch];
      ST_FB: fch <= fch + 3'd1;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == ST_FLAG && out_free) begin
      frame_status          <= STAT_OK;
      raw_throttle_filtered <= ymem[0][15:0];
      throttle_level        <= ymem[1][15:0];
      pitch_angle           <= ymem[2][13:0];
      roll_angle            <= ymem[3][13:0];
      yaw_rate              <= ymem[4][16:0];
      switch_bits           <= sw_c;
      flight_flags          <= f_c;
      signal_strength       <= cur.rssi;
      aux_command           <= aux_c;
      arm_command           <= armc_c;
    end else if (state == ST_FAIL && out_free) begin
      frame_status          <= cur.status;
      raw_throttle_filtered <= '0;
      throttle_level        <= '0;
      pitch_angle           <= '0;
      roll_angle            <= '0;
      yaw_rate              <= '0;
      switch_bits           <= '0;
      flight_flags          <= '0;
      signal_strength       <= '0;
      aux_command           <= CMD_NONE;
      arm_command           <= CMD_NONE;
    end
  end

endmodule

### hw/rtl/rc_frame_decoder.sv
// rc_frame_decoder: top level; config registers, front, queue and back.
// Depends on rcfd_pkg, rcfd_front, rcfd_queue, rcfd_back.
//
//   channel  | signals                           | carries
//   ---------+-----------------------------------+---------------------------
//   input    | in_valid / in_ready               | mode, rx_byte
//   output   | out_valid / out_ready             | frame_status .. arm_command
//   config   | cfg_valid / cfg_ready             | cfg_index, cfg_data
//
// The front handles a data byte, line error, ignored mode or frame end on
// acceptance. The back takes one record at a time: a good frame runs the log
// chain, three stick maps through one shared reciprocal divider and five
// filter passes; a failed frame goes straight to its result. Both can wait
// on an output stall. A two-entry queue lets the front keep taking bytes
// meanwhile; the input stalls only while the queue is full.
// Reset is synchronous; the frame byte store is not cleared.
module rc_frame_decoder import rcfd_pkg::*; #(
  parameter int FRAME_BYTES     = 13,
  parameter int LOG_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         frame_status,
  output logic [15:0]        raw_throttle_filtered,
  output logic [15:0]        throttle_level,
  output logic signed [13:0] pitch_angle,
  output logic signed [13:0] roll_angle,
  output logic signed [16:0] yaw_rate,
  output logic [7:0]         switch_bits,
  output logic [2:0]         flight_flags,
  output logic signed [7:0]  signal_strength,
  output logic [1:0]         aux_command,
  output logic [1:0]         arm_command,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  logic [7:0] header_value;
  logic [8:0] filter_weight;
  logic       lidar_hold_enable;
  logic       baro_hold_enable;
  logic       rssi_present;

  logic       full;
  logic       push;
  frame_rec_t push_rec;
  logic       pop;
  logic       rec_valid;
  frame_rec_t rec;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value      <= '0;
      filter_weight     <= 9'd128;
      lidar_hold_enable <= 1'b0;
      baro_hold_enable  <= 1'b0;
      rssi_present      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER: header_value      <= cfg_data[7:0];
        CFG_WEIGHT: filter_weight     <= cfg_data;
        CFG_LIDAR:  lidar_hold_enable <= cfg_data[0];
        CFG_BARO:   baro_hold_enable  <= cfg_data[0];
        CFG_RSSI:   rssi_present      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rcfd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .mode, .rx_byte,
    .header_value, .rssi_present, .full, .push, .push_rec
  );

  rcfd_queue u_queue (
    .clk, .rst, .push, .push_rec, .full, .pop, .rec_valid, .rec
  );

  rcfd_back #(.LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_back (
    .clk, .rst, .rec_valid, .rec, .pop,
    .filter_weight, .lidar_hold_enable, .baro_hold_enable,
    .out_valid, .out_ready, .frame_status, .raw_throttle_filtered,
    .throttle_level, .pitch_angle, .roll_angle, .yaw_rate, .switch_bits,
    .flight_flags, .signal_strength, .aux_command, .arm_command
  );

endmodule
